/* hdl/b64c_pkg.sv */
// ----------------------------------------------------------------------------
// b64c_pkg: shared types and helpers for the base64 codec
// Job format passed from the front end to the back end, alphabet mapping
// functions and queue sizing defaults.
// ----------------------------------------------------------------------------
package b64c_pkg;

  // default depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // job kinds
  localparam logic [1:0] KIND_ENC = 2'd0;
  localparam logic [1:0] KIND_DEC = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  // one finished group, ready to be emitted
  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] data;     // left-aligned group bits
    logic [1:0]  cnt;      // encode: number of data bytes in the group
    logic [1:0]  nres_m1;  // number of results minus one
    logic        last;     // group closes the stream
  } job_t;

  // classified input character
  typedef struct packed {
    logic       ok;
    logic       pad;
    logic [5:0] val;
  } sym_t;

  // 6-bit value to alphabet character
  function automatic logic [7:0] sym_char(input logic [5:0] v);
    logic [7:0] c;
    c = 8'd0;
    if (v < 6'd26) begin
      c = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'd97 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'd48 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2D;
    end
    return c;
  endfunction

  // alphabet character to 6-bit value, with pad and invalid flags
  function automatic sym_t sym_decode(input logic [7:0] c);
    sym_t s;
    s = '0;
    if (c >= 8'd65 && c <= 8'd90) begin
      s.ok  = 1'b1;
      s.val = 6'(c - 8'd65);
    end else if (c >= 8'd97 && c <= 8'd122) begin
      s.ok  = 1'b1;
      s.val = 6'(c - 8'd97 + 8'd26);
    end else if (c >= 8'd48 && c <= 8'd57) begin
      s.ok  = 1'b1;
      s.val = 6'(c - 8'd48 + 8'd52);
    end else if (c == 8'h2B) begin
      s.ok  = 1'b1;
      s.val = 6'd62;
    end else if (c == 8'h2D) begin
      s.ok  = 1'b1;
      s.val = 6'd63;
    end else if (c == PAD_CHAR) begin
      s.pad = 1'b1;
    end
    return s;
  endfunction

endpackage

/* hdl/b64c_fifo.sv */
// ----------------------------------------------------------------------------
// b64c_fifo: small job queue
// Register-based first-in first-out queue that decouples the front end from
// the back end; the head entry is visible while the queue is not empty.
// ----------------------------------------------------------------------------
module b64c_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [Width-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [Width-1:0] head_data
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head_data  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/b64c_front.sv */
// ----------------------------------------------------------------------------
// b64c_front: input side of the base64 codec
// Accepts items, gathers them into groups, checks decode characters and
// pushes one job per finished group, error or stream end into the queue.
// ----------------------------------------------------------------------------
module b64c_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  logic           cfg_direction,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  input  logic           q_full,
  output logic           push,
  output b64c_pkg::job_t push_job
);

  import b64c_pkg::*;

  logic        direction;
  logic [23:0] group_bits;
  logic [1:0]  group_count;
  logic [1:0]  pad_count;

  logic [23:0] group_bits_next;
  logic [1:0]  group_count_next;
  logic [1:0]  pad_count_next;

  logic        accept;
  sym_t        sym;
  logic        bad;
  logic [2:0]  enc_cnt;
  logic [23:0] enc_bits;
  logic [23:0] dec_bits;
  logic [1:0]  dec_pad;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign sym      = sym_decode(in_byte);
  assign enc_cnt  = {1'b0, group_count} + 3'd1;
  assign enc_bits = {group_bits[15:0], in_byte};
  assign dec_pad  = pad_count + {1'b0, sym.pad};
  assign dec_bits = {group_bits[17:0], (sym.pad ? 6'd0 : sym.val)};

  // invalid character, misplaced pad or data after pad
  always_comb begin
    bad = 1'b0;
    if (!sym.ok && !sym.pad) begin
      bad = 1'b1;
    end else if (sym.pad) begin
      bad = (group_count < 2'd2);
    end else begin
      bad = (pad_count != 2'd0);
    end
  end

  // group update and job building
  always_comb begin
    group_bits_next  = group_bits;
    group_count_next = group_count;
    pad_count_next   = pad_count;
    push             = 1'b0;
    push_job         = '0;
    push_job.last    = in_last;
    if (!direction) begin
      if (enc_cnt < 3'd3 && !in_last) begin
        group_bits_next  = enc_bits;
        group_count_next = enc_cnt[1:0];
      end else begin
        push             = 1'b1;
        push_job.kind    = KIND_ENC;
        push_job.cnt     = enc_cnt[1:0];
        push_job.nres_m1 = 2'd3;
        case (enc_cnt)
          3'd1:    push_job.data = {enc_bits[7:0], 16'h0000};
          3'd2:    push_job.data = {enc_bits[15:0], 8'h00};
          default: push_job.data = enc_bits;
        endcase
        group_bits_next  = '0;
        group_count_next = '0;
        pad_count_next   = '0;
      end
    end else begin
      if (bad || (group_count < 2'd3 && in_last)) begin
        push             = 1'b1;
        push_job.kind    = KIND_ERR;
        push_job.nres_m1 = 2'd0;
        group_bits_next  = '0;
        group_count_next = '0;
        pad_count_next   = '0;
      end else if (group_count < 2'd3) begin
        group_bits_next  = dec_bits;
        group_count_next = group_count + 2'd1;
        pad_count_next   = dec_pad;
      end else begin
        push             = 1'b1;
        push_job.kind    = KIND_DEC;
        push_job.data    = dec_bits;
        push_job.nres_m1 = (dec_pad >= 2'd2) ? 2'd0 : 2'd2 - dec_pad;
        group_bits_next  = '0;
        group_count_next = '0;
        pad_count_next   = '0;
      end
    end
    if (!accept) begin
      push             = 1'b0;
      group_bits_next  = group_bits;
      group_count_next = group_count;
      pad_count_next   = pad_count;
    end
  end

  // direction register and group state
  always_ff @(posedge clk) begin
    if (rst) begin
      direction   <= 1'b0;
      group_bits  <= '0;
      group_count <= '0;
      pad_count   <= '0;
    end else if (cfg_write) begin
      direction   <= cfg_direction;
      group_bits  <= '0;
      group_count <= '0;
      pad_count   <= '0;
    end else begin
      group_bits  <= group_bits_next;
      group_count <= group_count_next;
      pad_count   <= pad_count_next;
    end
  end

endmodule

/* hdl/b64c_back.sv */
// ----------------------------------------------------------------------------
// b64c_back: output side of the base64 codec
// Takes jobs from the queue and emits their results one per cycle through
// a registered output stage, unless out_ready holds the output back.
// ----------------------------------------------------------------------------
module b64c_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  b64c_pkg::job_t q_job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_run_last,
  output logic           out_stream_end,
  output logic           out_error
);

  import b64c_pkg::*;

  job_t       job;
  logic       busy;
  logic [1:0] idx;
  logic       advance;
  logic       final_res;
  logic [5:0] six;
  logic [7:0] res_byte;

  assign advance   = busy && (!out_valid || out_ready);
  assign final_res = (idx == job.nres_m1);
  assign pop       = q_valid && (!busy || (advance && final_res));

  // pick the field for the current result
  always_comb begin
    case (idx)
      2'd0:    six = job.data[23:18];
      2'd1:    six = job.data[17:12];
      2'd2:    six = job.data[11:6];
      default: six = job.data[5:0];
    endcase
    res_byte = 8'h00;
    case (job.kind)
      KIND_ENC: res_byte = (idx <= job.cnt) ? sym_char(six) : PAD_CHAR;
      KIND_DEC: begin
        case (idx)
          2'd0:    res_byte = job.data[23:16];
          2'd1:    res_byte = job.data[15:8];
          default: res_byte = job.data[7:0];
        endcase
      end
      default:  res_byte = 8'h00;
    endcase
  end

  // current job and result index
  always_ff @(posedge clk) begin
    if (pop) begin
      job <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (advance) begin
        if (final_res) begin
          busy <= 1'b0;
        end
        idx <= idx + 2'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte       <= res_byte;
      out_run_last   <= final_res;
      out_stream_end <= job.last;
      out_error      <= (job.kind == KIND_ERR);
    end
  end

endmodule

/* hdl/base64_codec_top.sv */
// Timing: a group's first result passes the job queue, the back end's job
// register and the output register after the item completing it is accepted,
// when the back end is idle; items that only fill a group give no result.
// Throughput: one item per cycle in while the queue is not full, one result
// per cycle out while out_ready is high; a three-byte group gives four results.
// Reset: synchronous rst clears direction (encode), group state, queue and
// output valid.
// ----------------------------------------------------------------------------
// base64_codec_top: streaming base64 encoder and decoder
// Front end gathers groups and queues jobs, back end emits results.
// ----------------------------------------------------------------------------
module base64_codec_top #(
  parameter int QueueDepth = b64c_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_direction,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_stream_end,
  output logic       out_error
);

  import b64c_pkg::*;

  job_t push_job;
  job_t head_job;
  logic push;
  logic q_full;
  logic q_valid;
  logic pop;

  // item intake and grouping
  b64c_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_direction (cfg_direction),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .q_full        (q_full),
    .push          (push),
    .push_job      (push_job)
  );

  // job queue
  b64c_fifo #(
    .Width ($bits(job_t)),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head_data  (head_job)
  );

  // result emission
  b64c_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_job          (head_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_stream_end (out_stream_end),
    .out_error      (out_error)
  );

endmodule

/* hdl/b64c_checker.sv */
// ----------------------------------------------------------------------------
// b64c_checker: port-level checks for the base64 codec
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
module b64c_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_error
);

  // reset empties the output stage
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // a stalled item holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("stalled output item changed");

  // an error item is a single zero byte
  a_error_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_error |-> out_byte == 8'h00 && out_run_last)
    else $error("malformed error item");

  // results of one job come without gaps
  a_run_gapless: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_run_last |=> out_valid)
    else $error("gap inside a run of results");

endmodule

bind base64_codec_top b64c_checker u_chk (.*);
